>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/otst_pkg.sv
// ---------------------------------------------------------------------------
// otst_pkg
// types, codes and constants of the one-shot timer table
// ---------------------------------------------------------------------------
package otst_pkg;

    localparam int SLOT_W         = 4;
    localparam int TIME_W         = 32;
    localparam int SLOT_LIMIT     = 16;
    localparam int NUM_TIMERS_DEF = 16;

    localparam logic [1:0] ACT_ARM    = 2'd0;
    localparam logic [1:0] ACT_ALLOC  = 2'd1;
    localparam logic [1:0] ACT_CANCEL = 2'd2;
    localparam logic [1:0] ACT_TICK   = 2'd3;

    localparam logic [1:0] EV_ARMED     = 2'd0;
    localparam logic [1:0] EV_CANCELLED = 2'd1;
    localparam logic [1:0] EV_EXPIRED   = 2'd2;
    localparam logic [1:0] EV_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [SLOT_W-1:0] timer_slot;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic [1:0]        event_code;
        logic              last_of_run;
    } t_out_item;

    // command travelling down the row of cells
    typedef struct packed {
        logic              active;
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] value;
        logic              found;
    } t_token;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        code;
    } t_event;

    function automatic int used_slots(input int n);
        return (n < SLOT_LIMIT) ? n : SLOT_LIMIT;
    endfunction

endpackage

>>> rtl/one_shot_timer_table.sv
// ---------------------------------------------------------------------------
// one_shot_timer_table
// table of one-shot timers built as a row of slot cells that a command
// token walks through, one cell per cycle while the output is not stalled
//
//   channel | direction | handshake                  | payload
//   in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
// every command runs from transfer to idle as follows: the token is loaded,
// passes each of the min(NUM_TIMERS,16) cells in turn, then leaves the row
// results leave at most one per cycle; a stalled output freezes the row
// reset clears valid bits and current time at once, no sweep
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module one_shot_timer_table #(
    parameter int NUM_TIMERS = otst_pkg::NUM_TIMERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  otst_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output otst_pkg::t_out_item o_out_data
);
    import otst_pkg::*;

    localparam int NUM_CELLS = used_slots(NUM_TIMERS);

    logic              r_busy;
    logic              n_busy;
    logic [TIME_W-1:0] r_cur_time;
    logic [TIME_W-1:0] n_cur_time;
    t_token            r_tok_in;
    t_token            n_tok_in;
    t_token            tok [NUM_CELLS+1];
    t_event            evts [NUM_CELLS];
    logic [NUM_CELLS:0] act_vec;
    logic              accept;
    logic              adv;
    logic              out_free;

    assign accept     = i_in_valid && !r_busy;
    assign adv        = r_busy && out_free;
    assign o_in_stall = r_busy;
    assign tok[0]     = r_tok_in;

    always_comb begin
        n_tok_in   = r_tok_in;
        n_cur_time = r_cur_time;
        n_busy     = r_busy;
        if (accept) begin
            n_busy          = 1'b1;
            n_tok_in.active = 1'b1;
            n_tok_in.op     = i_in_data.action;
            n_tok_in.slot   = i_in_data.timer_slot;
            n_tok_in.found  = 1'b0;
            if (i_in_data.action == ACT_TICK) begin
                n_tok_in.value = i_in_data.now_time;
                n_cur_time     = i_in_data.now_time;
            end else begin
                n_tok_in.value = r_cur_time + i_in_data.delay;
            end
        end else if (adv) begin
            n_tok_in.active = 1'b0;
            if (tok[NUM_CELLS].active) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_cur_time <= '0;
            r_tok_in   <= '0;
        end else begin
            r_busy     <= n_busy;
            r_cur_time <= n_cur_time;
            r_tok_in   <= n_tok_in;
        end
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        otst_cell #(
            .IDX (SLOT_W'(g))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .o_evt   (evts[g])
        );
    end

    otst_collect #(
        .NUM_CELLS (NUM_CELLS)
    ) u_collect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_evts      (evts),
        .i_end       (tok[NUM_CELLS]),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always_comb begin
        for (int k = 0; k <= NUM_CELLS; k++) begin
            act_vec[k] = tok[k].active;
        end
    end

    `ASSERT_IMPL(a_single_token, 1'b1, $onehot0(act_vec), "more than one command in the row")
    `ASSERT_IMPL(a_idle_empty, !r_busy, act_vec == '0, "command in the row while idle")
    `ASSERT_NEXT(a_transfer_busy, accept, r_busy && r_tok_in.active, "transfer did not start a run")

endmodule

>>> rtl/otst_cell.sv
// ---------------------------------------------------------------------------
// otst_cell
// one timer slot: valid bit, deadline, and one stage of the command chain
// ---------------------------------------------------------------------------
module otst_cell #(
    parameter logic [otst_pkg::SLOT_W-1:0] IDX = '0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  otst_pkg::t_token i_tok,
    output otst_pkg::t_token o_tok,
    output otst_pkg::t_event o_evt
);
    import otst_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [TIME_W-1:0] r_deadline;
    logic [TIME_W-1:0] n_deadline;
    t_token            r_tok;
    t_token            n_tok;
    t_event            evt;

    always_comb begin
        evt        = '0;
        evt.slot   = IDX;
        n_valid    = r_valid;
        n_deadline = r_deadline;
        n_tok      = i_tok;
        if (i_tok.active) begin
            unique case (i_tok.op)
                ACT_ARM: begin
                    if (i_tok.slot == IDX) begin
                        evt.hit    = 1'b1;
                        evt.code   = EV_ARMED;
                        n_valid    = 1'b1;
                        n_deadline = i_tok.value;
                    end
                end
                ACT_ALLOC: begin
                    if (!i_tok.found && !r_valid) begin
                        evt.hit     = 1'b1;
                        evt.code    = EV_ARMED;
                        n_valid     = 1'b1;
                        n_deadline  = i_tok.value;
                        n_tok.found = 1'b1;
                    end
                end
                ACT_CANCEL: begin
                    if (i_tok.slot == IDX) begin
                        evt.hit  = 1'b1;
                        evt.code = EV_CANCELLED;
                        n_valid  = 1'b0;
                    end
                end
                ACT_TICK: begin
                    if (r_valid && (i_tok.value > r_deadline)) begin
                        evt.hit  = 1'b1;
                        evt.code = EV_EXPIRED;
                        n_valid  = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_deadline <= n_deadline;
        end
    end

    assign o_tok = r_tok;
    assign o_evt = evt;

endmodule

>>> rtl/otst_collect.sv
// ---------------------------------------------------------------------------
// otst_collect
// merges cell events, holds one back to mark the last, drives the output
// ---------------------------------------------------------------------------
module otst_collect #(
    parameter int NUM_CELLS = otst_pkg::NUM_TIMERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  otst_pkg::t_event    i_evts [NUM_CELLS],
    input  otst_pkg::t_token    i_end,
    output logic                o_free,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output otst_pkg::t_out_item o_out_data
);
    import otst_pkg::*;

    t_event    evt;
    t_event    r_pend;
    t_event    n_pend;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      full;

    always_comb begin
        evt = '0;
        for (int k = 0; k < NUM_CELLS; k++) begin
            if (i_evts[k].hit) begin
                evt = evt | i_evts[k];
            end
        end
    end

    assign full   = i_end.active && (i_end.op == ACT_ALLOC) && !i_end.found;
    assign o_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (i_adv) begin
            if (i_end.active) begin
                if (full) begin
                    n_out_valid = 1'b1;
                    n_out       = '{slot_out: '0, event_code: EV_FULL, last_of_run: 1'b1};
                end else if (r_pend.hit) begin
                    n_out_valid = 1'b1;
                    n_out       = '{slot_out: r_pend.slot, event_code: r_pend.code,
                                    last_of_run: 1'b1};
                    n_pend.hit  = 1'b0;
                end
            end else if (evt.hit) begin
                if (r_pend.hit) begin
                    n_out_valid = 1'b1;
                    n_out       = '{slot_out: r_pend.slot, event_code: r_pend.code,
                                    last_of_run: 1'b0};
                end
                n_pend = evt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend.slot <= n_pend.slot;
        r_pend.code <= n_pend.code;
        r_out       <= n_out;
        if (!i_rst_n) begin
            r_pend.hit  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend.hit  <= n_pend.hit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> verif/tb_one_shot_timer_table.sv
// ---------------------------------------------------------------------------
// tb_one_shot_timer_table
// self-checking bench for the one-shot timer table: every accepted command
// updates a local copy of the slot table and queues the events it must
// cause; each event leaving the block is checked against the oldest one
// ---------------------------------------------------------------------------
module tb_one_shot_timer_table;

    import otst_pkg::*;

    localparam int LATENCY     = SLOT_LIMIT + 2;
    localparam int QUIET_LIMIT = 2000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    // local copy of the slot table
    logic              timer_armed [SLOT_LIMIT];
    logic [TIME_W-1:0] timer_deadline [SLOT_LIMIT];
    logic [TIME_W-1:0] time_now;

    t_out_item pending_events[$];
    t_out_item head_event;
    int        mismatches   = 0;
    int        quiet_cycles = 0;
    int        stall_left   = 0;
    bit        idle_en      = 1'b1;

    one_shot_timer_table u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #10 clk = ~clk;

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s", what);
        end
    endtask

    function automatic t_out_item make_event(input int slot, input logic [1:0] code,
                                             input logic last);
        t_out_item ev;
        ev.slot_out    = SLOT_W'(slot);
        ev.event_code  = code;
        ev.last_of_run = last;
        return ev;
    endfunction

    // append one expected event at the tail of the queue
    function automatic void enqueue_event(input t_out_item ev);
        pending_events.insert(pending_events.size(), ev);
    endfunction

    // apply one command to the local table and queue the events it causes
    function automatic void apply_command(input t_in_item cmd);
        t_out_item ev;
        int        idx;
        int        free_slot;
        int        fired;
        fired     = 0;
        free_slot = -1;
        case (cmd.action)
            ACT_ARM: begin
                timer_armed[cmd.timer_slot]    = 1'b1;
                timer_deadline[cmd.timer_slot] = time_now + cmd.delay;
                enqueue_event(make_event(cmd.timer_slot, EV_ARMED, 1'b1));
            end
            ACT_ALLOC: begin
                for (idx = SLOT_LIMIT - 1; idx >= 0; idx--) begin
                    if (!timer_armed[idx]) free_slot = idx;
                end
                if (free_slot < 0) begin
                    enqueue_event(make_event(0, EV_FULL, 1'b1));
                end else begin
                    timer_armed[free_slot]    = 1'b1;
                    timer_deadline[free_slot] = time_now + cmd.delay;
                    enqueue_event(make_event(free_slot, EV_ARMED, 1'b1));
                end
            end
            ACT_CANCEL: begin
                timer_armed[cmd.timer_slot] = 1'b0;
                enqueue_event(make_event(cmd.timer_slot, EV_CANCELLED, 1'b1));
            end
            default: begin
                time_now = cmd.now_time;
                for (idx = 0; idx < SLOT_LIMIT; idx++) begin
                    if (timer_armed[idx] && time_now > timer_deadline[idx]) begin
                        timer_armed[idx] = 1'b0;
                        enqueue_event(make_event(idx, EV_EXPIRED, 1'b0));
                        fired++;
                    end
                end
                if (fired > 0) begin
                    ev = pending_events.pop_back();
                    ev.last_of_run = 1'b1;
                    enqueue_event(ev);
                end
            end
        endcase
    endfunction

    function automatic t_in_item make_cmd(input logic [1:0] action, input int slot,
                                          input logic [TIME_W-1:0] delay,
                                          input logic [TIME_W-1:0] now_time);
        t_in_item cmd;
        cmd.action     = action;
        cmd.timer_slot = SLOT_W'(slot);
        cmd.delay      = delay;
        cmd.now_time   = now_time;
        return cmd;
    endfunction

    function automatic t_in_item random_command();
        t_in_item cmd;
        int       pick;
        pick           = $urandom_range(0, 99);
        cmd.timer_slot = SLOT_W'($urandom);
        cmd.now_time   = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            cmd.delay = $urandom;
        end else begin
            cmd.delay = $urandom_range(0, 300);
        end
        if (pick < 30) begin
            cmd.action = ACT_ARM;
        end else if (pick < 55) begin
            cmd.action = ACT_ALLOC;
        end else if (pick < 70) begin
            cmd.action = ACT_CANCEL;
        end else begin
            cmd.action = ACT_TICK;
            case ($urandom_range(0, 19))
                0:       cmd.now_time = $urandom;
                1:       cmd.now_time = time_now - $urandom_range(0, 50);
                default: cmd.now_time = time_now + $urandom_range(0, 250);
            endcase
        end
        return cmd;
    endfunction

    // hold the command until the block takes it, then predict
    task automatic send_command(input t_in_item cmd);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        do @(posedge clk); while (in_stall);
        apply_command(cmd);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_events.size() != 0);
    endtask

    task automatic test_allocate_until_full();
        int n;
        for (n = 0; n < SLOT_LIMIT; n++) begin
            send_command(make_cmd(ACT_ALLOC, 0, '0, '0));
        end
        send_command(make_cmd(ACT_ALLOC, 15, '1, '1));
    endtask

    // deadline equal to the new time stays armed, one past it fires all
    task automatic test_tick_boundary();
        send_command(make_cmd(ACT_TICK, 0, '0, 32'd0));
        send_command(make_cmd(ACT_TICK, 0, '0, 32'd1));
    endtask

    task automatic test_arm_and_cancel();
        send_command(make_cmd(ACT_ARM, 0, '1, '0));
        send_command(make_cmd(ACT_ARM, 15, '0, '0));
        send_command(make_cmd(ACT_ARM, 7, 32'd5, '0));
        send_command(make_cmd(ACT_CANCEL, 7, '0, '0));
        send_command(make_cmd(ACT_CANCEL, 9, '0, '0));
        send_command(make_cmd(ACT_TICK, 0, '0, 32'd0));
        send_command(make_cmd(ACT_TICK, 0, '0, '1));
    endtask

    task automatic test_random_traffic(input int count, input bit allow_idle);
        int n;
        for (n = 0; n < count; n++) begin
            if (n % 30 == 0) begin
                idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            end
            send_command(random_command());
        end
    endtask

    // result check and output stall bursts
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_events.size() == 0) begin
                note_failure($sformatf("unexpected transfer: slot %0d code %0d last %0d",
                    out_data.slot_out, out_data.event_code, out_data.last_of_run));
            end else begin
                head_event = pending_events.pop_front();
                if (out_data.slot_out != head_event.slot_out
                        || out_data.event_code != head_event.event_code
                        || out_data.last_of_run != head_event.last_of_run) begin
                    note_failure($sformatf(
                        "mismatch: expected slot %0d code %0d last %0d, got %0d %0d %0d",
                        head_event.slot_out, head_event.event_code,
                        head_event.last_of_run, out_data.slot_out,
                        out_data.event_code, out_data.last_of_run));
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (idle_en && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("one_shot_timer_table verification failed");
                $finish;
            end
        end
    end

    initial begin
        foreach (timer_armed[k]) begin
            timer_armed[k]    = 1'b0;
            timer_deadline[k] = '0;
        end
        time_now = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_allocate_until_full();
        test_tick_boundary();
        test_arm_and_cancel();
        test_random_traffic(200, 1'b1);
        wait_for_drain();
        test_random_traffic(140, 1'b1);
        wait_for_drain();
        test_random_traffic(115, 1'b0);
        wait_for_drain();
        repeat (2 * LATENCY) @(posedge clk);

        mismatches += pending_events.size();
        if (mismatches == 0) begin
            $display("one_shot_timer_table verification clean");
        end else begin
            $display("one_shot_timer_table verification failed");
        end
        $finish;
    end

endmodule
